/* design/assert_macros.svh */
// Assertion macros shared by the sorted priority queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising clock edge out of reset.
`define SPQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
// Next-cycle implication, checked at every rising clock edge out of reset.
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define SPQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* design/spq_pkg.sv */
// Types and codes shared by the sorted priority queue modules.
package spq_pkg;

	// Operation codes of an input item.
	localparam logic [1:0] OP_PUSH    = 2'd0;
	localparam logic [1:0] OP_SERVE   = 2'd1;
	localparam logic [1:0] OP_LIST    = 2'd2;
	localparam logic [1:0] OP_UNKNOWN = 2'd3;

	// Status codes of a result item.
	localparam logic [2:0] STS_SERVED  = 3'd0;
	localparam logic [2:0] STS_EMPTY   = 3'd1;
	localparam logic [2:0] STS_FULL    = 3'd2;
	localparam logic [2:0] STS_ENTRY   = 3'd3;
	localparam logic [2:0] STS_END     = 3'd4;
	localparam logic [2:0] STS_UNKNOWN = 3'd5;

	// Command that every cell of the chain executes.
	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_PUSH,
		CMD_SHIFT
	} cell_cmd_t;

	// Payload of one queue entry.
	typedef struct packed {
		logic signed [31:0] id;
		logic signed [31:0] prio;
	} entry_t;

	// Broadcast control for the chain.
	typedef struct packed {
		cell_cmd_t cmd;
		entry_t    data;
	} cell_ctl_t;

endpackage

/* design/spq_cell.sv */
// One cell of the sorted chain: holds a single entry and its valid bit.
module spq_cell
	import spq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      left_keep,
	input  logic      left_valid,
	input  entry_t    left_data,
	input  logic      right_valid,
	input  entry_t    right_data,
	output logic      valid,
	output entry_t    data,
	output logic      keep
);

	logic   valid_q;
	entry_t data_q;

	// The cell keeps its entry on a push when that entry outranks the new one.
	assign keep = valid_q && ($signed(data_q.prio) > $signed(ctl.data.prio));

	// Valid bit: a push fills from the left neighbor or the new entry, a shift
	// pulls from the right neighbor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (ctl.cmd)
				CMD_PUSH: begin
					if (!keep) begin
						valid_q <= left_keep ? 1'b1 : left_valid;
					end
				end
				CMD_SHIFT: valid_q <= right_valid;
				default:   valid_q <= valid_q;
			endcase
		end
	end

	// Entry payload follows the same selection and needs no reset.
	always_ff @(posedge clk) begin
		unique case (ctl.cmd)
			CMD_PUSH: begin
				if (!keep) begin
					data_q <= left_keep ? ctl.data : left_data;
				end
			end
			CMD_SHIFT: data_q <= right_data;
			default:   data_q <= data_q;
		endcase
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

/* design/sorted_priority_queue_top.sv */
// Top level of the sorted priority queue: control, cell chain and output register.
// Push, serve and unknown give a result that is registered and shown the next cycle; a push with room gives none.
// A new item is taken whenever the control is idle and the output register is free.
// List rotates the whole chain of CAPACITY cells, one cell a cycle while the output can take a valid head,
// then sends the end marker.
// Asynchronous reset clears the valid bits of all cells; the queue then reads as empty.
`include "assert_macros.svh"
module sorted_priority_queue_top
	import spq_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic signed [31:0] item_id,
	input  logic signed [31:0] item_priority,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic signed [31:0] out_id,
	output logic signed [31:0] out_priority,
	output logic               last
);

	localparam int ROT_W = $clog2(CAPACITY + 1);

	// Controller state codes.
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_LIST = 1'b1;

	logic               state_q;
	logic [ROT_W-1:0]   rot_q;
	logic               out_valid_q;
	logic [2:0]         status_q;
	logic signed [31:0] id_q;
	logic signed [31:0] prio_q;
	logic               last_q;

	logic [CAPACITY-1:0] valid_vec;
	logic [CAPACITY-1:0] keep_vec;
	entry_t              data_vec [CAPACITY];

	cell_ctl_t          ctl;
	logic               wrap;
	logic               slot_free;
	logic               in_acc;
	logic               full;
	logic               head_valid;
	logic               rot_done;
	logic               rot_step;
	logic               list_start;
	logic               list_end;
	logic               emit;
	logic [2:0]         e_status;
	logic signed [31:0] e_id;
	logic signed [31:0] e_prio;
	logic               push_ok;
	logic               serve_ok;

	assign slot_free  = !out_valid_q || out_ready;
	assign in_ready   = (state_q == ST_IDLE) && slot_free;
	assign in_acc     = in_valid && in_ready;
	assign full       = valid_vec[CAPACITY-1];
	assign head_valid = valid_vec[0];
	assign rot_done   = (rot_q == ROT_W'(CAPACITY));
	assign push_ok    = in_acc && (operation == OP_PUSH) && !full;
	assign serve_ok   = in_acc && (operation == OP_SERVE) && head_valid;

	// Decode the accepted item or the next list step into a chain command
	// and an optional result.
	always_comb begin
		ctl.cmd       = CMD_HOLD;
		ctl.data.id   = item_id;
		ctl.data.prio = item_priority;
		wrap          = 1'b0;
		rot_step      = 1'b0;
		list_start    = 1'b0;
		list_end      = 1'b0;
		emit          = 1'b0;
		e_status      = STS_UNKNOWN;
		e_id          = '0;
		e_prio        = '0;
		if (state_q == ST_IDLE) begin
			if (in_acc) begin
				unique case (operation)
					OP_PUSH: begin
						if (full) begin
							emit     = 1'b1;
							e_status = STS_FULL;
						end else begin
							ctl.cmd = CMD_PUSH;
						end
					end
					OP_SERVE: begin
						emit = 1'b1;
						if (head_valid) begin
							ctl.cmd  = CMD_SHIFT;
							e_status = STS_SERVED;
							e_id     = data_vec[0].id;
						end else begin
							e_status = STS_EMPTY;
						end
					end
					OP_LIST: list_start = 1'b1;
					default: begin
						emit     = 1'b1;
						e_status = STS_UNKNOWN;
					end
				endcase
			end
		end else begin
			if (!rot_done) begin
				// Rotate by one cell; a valid head is sent out on the way.
				if (!head_valid || slot_free) begin
					ctl.cmd  = CMD_SHIFT;
					wrap     = 1'b1;
					rot_step = 1'b1;
					if (head_valid) begin
						emit     = 1'b1;
						e_status = STS_ENTRY;
						e_id     = data_vec[0].id;
						e_prio   = data_vec[0].prio;
					end
				end
			end else if (slot_free) begin
				emit     = 1'b1;
				e_status = STS_END;
				list_end = 1'b1;
			end
		end
	end

	// Chain of cells; the tail pulls the head on a rotation and nothing on a serve.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic   l_keep;
		logic   l_valid;
		entry_t l_data;
		logic   r_valid;
		entry_t r_data;
		if (g == 0) begin : g_head
			assign l_keep  = 1'b1;
			assign l_valid = 1'b0;
			assign l_data  = ctl.data;
		end else begin : g_mid
			assign l_keep  = keep_vec[g-1];
			assign l_valid = valid_vec[g-1];
			assign l_data  = data_vec[g-1];
		end
		if (g == CAPACITY - 1) begin : g_tail
			assign r_valid = wrap && valid_vec[0];
			assign r_data  = data_vec[0];
		end else begin : g_body
			assign r_valid = valid_vec[g+1];
			assign r_data  = data_vec[g+1];
		end
		spq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.left_keep   (l_keep),
			.left_valid  (l_valid),
			.left_data   (l_data),
			.right_valid (r_valid),
			.right_data  (r_data),
			.valid       (valid_vec[g]),
			.data        (data_vec[g]),
			.keep        (keep_vec[g])
		);
	end

	// Controller state and rotation counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rot_q   <= '0;
		end else begin
			if (list_start) begin
				state_q <= ST_LIST;
				rot_q   <= '0;
			end else if (list_end) begin
				state_q <= ST_IDLE;
			end else if (rot_step) begin
				rot_q <= rot_q + ROT_W'(1);
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= emit;
		end
	end

	// Output register payload, loaded with every transfer into the slot.
	always_ff @(posedge clk) begin
		if (slot_free && emit) begin
			status_q <= e_status;
			id_q     <= e_id;
			prio_q   <= e_prio;
			last_q   <= (e_status != STS_ENTRY);
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_id       = id_q;
	assign out_priority = prio_q;
	assign last         = last_q;

	// Outside a list, occupied cells always form one run starting at the head.
	`SPQ_ASSERT_IMPLY(a_contiguous, clk, arst_n, state_q == ST_IDLE, ((valid_vec >> 1) & ~valid_vec) == '0)
	// A push with room adds exactly one entry.
	`SPQ_ASSERT_NEXT(a_push_grows, clk, arst_n, push_ok, $countones(valid_vec) == $past($countones(valid_vec)) + 1)
	// A serve of a non-empty queue removes exactly one entry.
	`SPQ_ASSERT_NEXT(a_serve_shrinks, clk, arst_n, serve_ok, $countones(valid_vec) + 1 == $past($countones(valid_vec)))
	// The rotation never runs past one full turn of the chain.
	`SPQ_ASSERT_IMPLY(a_rot_bound, clk, arst_n, state_q == ST_LIST, rot_q <= ROT_W'(CAPACITY))

endmodule
